FILE: design/hppc_pkg.sv
// ----------------------------------------------------------------------------
// Pixel compositor package
// Shared types and constants for the layer compositor.
// ----------------------------------------------------------------------------
package hppc_pkg;

  localparam logic [2:0] LayerSprite   = 3'd4;
  localparam logic [2:0] LayerBackdrop = 3'd5;

  localparam logic [1:0] FxNone     = 2'd0;
  localparam logic [1:0] FxAlpha    = 2'd1;
  localparam logic [1:0] FxBrighten = 2'd2;
  localparam logic [1:0] FxDarken   = 2'd3;

  localparam logic [2:0] RegBgMode    = 3'd0;
  localparam logic [2:0] RegBlank     = 3'd1;
  localparam logic [2:0] RegLayerEn   = 3'd2;
  localparam logic [2:0] RegBgPrio    = 3'd3;
  localparam logic [2:0] RegWinMasks  = 3'd4;
  localparam logic [2:0] RegBlendCtl  = 3'd5;
  localparam logic [2:0] RegBlendCoef = 3'd6;
  localparam logic [2:0] RegBackdrop  = 3'd7;

  localparam logic [23:0] WhiteRgb = 24'hF8F8F8;

  // Result of the layer selection stage.
  typedef struct packed {
    logic [2:0]  lay0;
    logic [2:0]  lay1;
    logic [14:0] color0;
    logic [14:0] color1;
    logic        fx_en;
    logic        alpha_obj;
    logic        blank;
  } sel_t;

  // Chosen effect and its two coefficients.
  typedef struct packed {
    logic [14:0] c1;
    logic [14:0] c2;
    logic [1:0]  effect;
    logic [4:0]  k1;
    logic [4:0]  k2;
    logic        blank;
  } fx_t;

  function automatic logic [4:0] clamp16(input logic [4:0] v);
    return (v > 5'd16) ? 5'd16 : v;
  endfunction

endpackage

FILE: design/hppc_effect.sv
// ----------------------------------------------------------------------------
// Pixel compositor effect unit
// Two-stage color effect: products are registered, then summed and clamped.
// ----------------------------------------------------------------------------
module hppc_effect (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  hppc_pkg::fx_t    fx_i,
  output logic             valid_o,
  output logic [23:0]      rgb_o
);

  logic [2:0][9:0] pa_d, pa_q, pb_d, pb_q;
  logic [2:0][4:0] base_q;
  logic [1:0]      eff_q;
  logic            blank_q, v1_q, v2_q;
  logic [23:0]     rgb_d, rgb_q;

  always_comb begin
    logic [4:0] a, b;
    for (int k = 0; k < 3; k++) begin
      a = fx_i.c1[5*k +: 5];
      b = fx_i.c2[5*k +: 5];
      unique case (fx_i.effect)
        hppc_pkg::FxAlpha: begin
          pa_d[k] = {5'b0, a} * {5'b0, fx_i.k1};
          pb_d[k] = {5'b0, b} * {5'b0, fx_i.k2};
        end
        hppc_pkg::FxBrighten: begin
          pa_d[k] = {5'b0, 5'd31 - a} * {5'b0, fx_i.k1};
          pb_d[k] = '0;
        end
        hppc_pkg::FxDarken: begin
          pa_d[k] = {5'b0, a} * {5'b0, fx_i.k1};
          pb_d[k] = '0;
        end
        default: begin
          pa_d[k] = '0;
          pb_d[k] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    eff_q   <= fx_i.effect;
    blank_q <= fx_i.blank;
    for (int k = 0; k < 3; k++) begin
      base_q[k] <= fx_i.c1[5*k +: 5];
    end
    rgb_q <= rgb_d;
  end

  always_comb begin
    logic [10:0] s;
    logic [4:0]  c;
    rgb_d = '0;
    for (int k = 0; k < 3; k++) begin
      s = {1'b0, pa_q[k]} + {1'b0, pb_q[k]};
      unique case (eff_q)
        hppc_pkg::FxAlpha:    c = (s[10:4] > 7'd31) ? 5'd31 : s[8:4];
        hppc_pkg::FxBrighten: c = base_q[k] + s[8:4];
        hppc_pkg::FxDarken:   c = base_q[k] - s[8:4];
        default:              c = base_q[k];
      endcase
      rgb_d[8*(2-k) +: 8] = {c, 3'b000};
    end
    if (blank_q) begin
      rgb_d = hppc_pkg::WhiteRgb;
    end
  end

  assign valid_o = v2_q;
  assign rgb_o   = rgb_q;

endmodule

FILE: design/handheld_ppu_pixel_compositor.sv
// ----------------------------------------------------------------------------
// Handheld PPU pixel compositor
// Ranks backgrounds and sprite per pixel, applies windows and color effects.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  pixel     start, busy, bg*/sprite*         in
//  config    cfg_valid_i/ready_o, idx, data   in
//  result    done_o, pixel_rgb_o              out
//
// One word is accepted every cycle; busy is always low.
// Each word's result goes through sel_q, fx_q and the effect unit to pixel_rgb_o.
// Stage 1 selects the layers, stage 2 the effect, stages 3 and 4 compute it.
// Reset clears the config registers and valid bits; the receiver cannot stall.
module handheld_ppu_pixel_compositor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] bg0_pixel_i,
  input  logic [15:0] bg1_pixel_i,
  input  logic [15:0] bg2_pixel_i,
  input  logic [15:0] bg3_pixel_i,
  input  logic [15:0] sprite_pixel_i,
  input  logic [1:0]  sprite_priority_i,
  input  logic        sprite_alpha_i,
  input  logic        sprite_window_i,
  input  logic        inside_win0_i,
  input  logic        inside_win1_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output logic        done_o,
  output logic [23:0] pixel_rgb_o
);

  logic [2:0]  bg_mode_q;
  logic        blank_q;
  logic [7:0]  layer_en_q, bg_prio_q;
  logic [23:0] win_masks_q;
  logic [13:0] blend_ctl_q;
  logic [14:0] coef_q, backdrop_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_mode_q   <= '0;
      blank_q     <= '0;
      layer_en_q  <= '0;
      bg_prio_q   <= '0;
      win_masks_q <= '0;
      blend_ctl_q <= '0;
      coef_q      <= '0;
      backdrop_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hppc_pkg::RegBgMode:    bg_mode_q   <= cfg_data_i[2:0];
        hppc_pkg::RegBlank:     blank_q     <= cfg_data_i[0];
        hppc_pkg::RegLayerEn:   layer_en_q  <= cfg_data_i[7:0];
        hppc_pkg::RegBgPrio:    bg_prio_q   <= cfg_data_i[7:0];
        hppc_pkg::RegWinMasks:  win_masks_q <= cfg_data_i;
        hppc_pkg::RegBlendCtl:  blend_ctl_q <= cfg_data_i[13:0];
        hppc_pkg::RegBlendCoef: coef_q      <= cfg_data_i[14:0];
        hppc_pkg::RegBackdrop:  backdrop_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Stage 1: window mask and layer ranking.
  logic [3:0][15:0] bgs;
  assign bgs = {bg3_pixel_i, bg2_pixel_i, bg1_pixel_i, bg0_pixel_i};

  hppc_pkg::sel_t sel_d, sel_q;
  logic           v1_q;
  logic           v2_q;

  always_comb begin
    logic [5:0] mask;
    logic [3:0] inrange, vis;
    logic [2:0] prio0, prio1, sp;
    logic [2:0] lay0, lay1;
    logic [1:0] bp;
    logic       aobj;
    unique case (bg_mode_q)
      3'd0:                inrange = 4'b1111;
      3'd1:                inrange = 4'b0111;
      3'd2:                inrange = 4'b1100;
      3'd3, 3'd4, 3'd5:    inrange = 4'b0100;
      default:             inrange = 4'b0000;
    endcase
    mask = 6'h3F;
    if (layer_en_q[7:5] != 3'b000) begin
      if (layer_en_q[5] && inside_win0_i)       mask = win_masks_q[5:0];
      else if (layer_en_q[6] && inside_win1_i)  mask = win_masks_q[11:6];
      else if (layer_en_q[7] && sprite_window_i) mask = win_masks_q[23:18];
      else                                      mask = win_masks_q[17:12];
    end
    for (int b = 0; b < 4; b++) begin
      vis[b] = inrange[b] & layer_en_q[b] & mask[b] & ~bgs[b][15];
    end
    prio0 = 3'd4; prio1 = 3'd4;
    lay0 = hppc_pkg::LayerBackdrop; lay1 = hppc_pkg::LayerBackdrop;
    // Front to back: lower priority value, then lower index.
    for (int p = 0; p < 4; p++) begin
      for (int b = 0; b < 4; b++) begin
        bp = bg_prio_q[2*b +: 2];
        if (vis[b] && bp == p[1:0]) begin
          if (lay0 == hppc_pkg::LayerBackdrop) begin
            lay0 = b[2:0]; prio0 = {1'b0, bp};
          end else if (lay1 == hppc_pkg::LayerBackdrop) begin
            lay1 = b[2:0]; prio1 = {1'b0, bp};
          end
        end
      end
    end
    aobj = 1'b0;
    sp = {1'b0, sprite_priority_i};
    if (mask[4] && layer_en_q[4] && !sprite_pixel_i[15]) begin
      if (sp <= prio0) begin
        lay1 = lay0;
        lay0 = hppc_pkg::LayerSprite;
        aobj = sprite_alpha_i;
      end else if (sp <= prio1) begin
        lay1 = hppc_pkg::LayerSprite;
      end
    end
    sel_d.lay0 = lay0;
    sel_d.lay1 = lay1;
    sel_d.color0 = (lay0 == hppc_pkg::LayerSprite) ? sprite_pixel_i[14:0] :
                   (lay0 == hppc_pkg::LayerBackdrop) ? backdrop_q : bgs[lay0[1:0]][14:0];
    sel_d.color1 = (lay1 == hppc_pkg::LayerSprite) ? sprite_pixel_i[14:0] :
                   (lay1 == hppc_pkg::LayerBackdrop) ? backdrop_q : bgs[lay1[1:0]][14:0];
    sel_d.fx_en = mask[5] | aobj;
    sel_d.alpha_obj = aobj;
    sel_d.blank = blank_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start;
      v2_q <= v1_q;
    end
  end

  // Stage 2: effect decision.
  hppc_pkg::fx_t fx_d, fx_q;

  always_comb begin
    logic [1:0] eff;
    logic       dst, src;
    eff = blend_ctl_q[1:0];
    dst = blend_ctl_q[3'd2 + {1'b0, sel_q.lay0}];
    src = blend_ctl_q[4'd8 + {1'b0, sel_q.lay1}];
    fx_d.c1 = sel_q.color0;
    fx_d.c2 = sel_q.color1;
    fx_d.blank = sel_q.blank;
    fx_d.effect = hppc_pkg::FxNone;
    if (sel_q.fx_en) begin
      if (sel_q.alpha_obj && src) fx_d.effect = hppc_pkg::FxAlpha;
      else if (dst && eff != hppc_pkg::FxNone && (src || eff != hppc_pkg::FxAlpha))
        fx_d.effect = eff;
    end
    if (fx_d.effect == hppc_pkg::FxAlpha) begin
      fx_d.k1 = hppc_pkg::clamp16(coef_q[4:0]);
      fx_d.k2 = hppc_pkg::clamp16(coef_q[9:5]);
    end else begin
      fx_d.k1 = hppc_pkg::clamp16(coef_q[14:10]);
      fx_d.k2 = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
    fx_q  <= fx_d;
  end

  hppc_effect u_effect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .fx_i    (fx_q),
    .valid_o (done_o),
    .rgb_o   (pixel_rgb_o)
  );

`ifndef NO_ASSERTIONS
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |=> ##1 done_o) else $error("result lost");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(v2_q, 2)) else $error("unexpected result");
`endif

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Pixel compositor testbench
// Drives pixel words and register writes into the compositor, predicts each
// composed pixel in a model of its own, and compares every result in order.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [15:0] bg [4];
    logic [15:0] spr;
    logic [1:0]  spr_prio;
    logic        spr_alpha;
    logic        spr_win;
    logic        win0;
    logic        win1;
  } pix_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] bg0_pixel = '0, bg1_pixel = '0, bg2_pixel = '0, bg3_pixel = '0;
  logic [15:0] sprite_pixel = '0;
  logic [1:0]  sprite_priority = '0;
  logic        sprite_alpha = 1'b0, sprite_window = 1'b0;
  logic        inside_win0 = 1'b0, inside_win1 = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        done;
  logic [23:0] pixel_rgb;

  handheld_ppu_pixel_compositor i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .bg0_pixel_i      (bg0_pixel),
    .bg1_pixel_i      (bg1_pixel),
    .bg2_pixel_i      (bg2_pixel),
    .bg3_pixel_i      (bg3_pixel),
    .sprite_pixel_i   (sprite_pixel),
    .sprite_priority_i(sprite_priority),
    .sprite_alpha_i   (sprite_alpha),
    .sprite_window_i  (sprite_window),
    .inside_win0_i    (inside_win0),
    .inside_win1_i    (inside_win1),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .done_o           (done),
    .pixel_rgb_o      (pixel_rgb)
  );

  always #10 clk_i = ~clk_i;

  logic [2:0]  mode_q = '0;
  logic        blank_q = 1'b0;
  logic [7:0]  layer_en_q = '0, bg_prio_q = '0;
  logic [23:0] win_masks_q = '0;
  logic [13:0] blend_ctl_q = '0;
  logic [14:0] coef_q = '0, backdrop_q = '0;

  pix_word_t   pending_words [$];
  logic [23:0] expected_rgb [$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          gap_left = 0;
  bit          driving = 1'b0;
  logic        busy_q;

  function automatic logic [4:0] sat16(input logic [4:0] v);
    return (v > 5'd16) ? 5'd16 : v;
  endfunction

  function automatic logic [14:0] layer_rgb(input logic [2:0] lay, input pix_word_t w);
    if (lay < hppc_pkg::LayerSprite) return w.bg[lay[1:0]][14:0];
    if (lay == hppc_pkg::LayerSprite) return w.spr[14:0];
    return backdrop_q;
  endfunction

  function automatic logic [14:0] mix_color(input logic [14:0] top, input logic [14:0] low,
                                            input logic [1:0] fx);
    logic [14:0] res;
    int          a, b, v;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      a = top[5*k +: 5];
      b = low[5*k +: 5];
      case (fx)
        hppc_pkg::FxAlpha: begin
          v = (a * sat16(coef_q[4:0]) + b * sat16(coef_q[9:5])) >> 4;
          if (v > 31) v = 31;
        end
        hppc_pkg::FxBrighten: v = a + (((31 - a) * sat16(coef_q[14:10])) >> 4);
        hppc_pkg::FxDarken:   v = a - ((a * sat16(coef_q[14:10])) >> 4);
        default:              v = a;
      endcase
      res[5*k +: 5] = v[4:0];
    end
    return res;
  endfunction

  function automatic logic [23:0] compose_pixel(input pix_word_t w);
    int          lo, hi, prio0, prio1, sp;
    logic [2:0]  lay0, lay1;
    logic [5:0]  mask;
    logic [14:0] color, below;
    logic [1:0]  fx;
    logic        any_bg, alpha_obj, has_dst, has_src;
    if (blank_q) return hppc_pkg::WhiteRgb;
    any_bg = 1'b1;
    case (mode_q)
      3'd0: begin lo = 0; hi = 3; end
      3'd1: begin lo = 0; hi = 2; end
      3'd2: begin lo = 2; hi = 3; end
      3'd3, 3'd4, 3'd5: begin lo = 2; hi = 2; end
      default: begin lo = 0; hi = 0; any_bg = 1'b0; end
    endcase
    mask = 6'h3F;
    if (layer_en_q[7:5] != 0) begin
      if (layer_en_q[5] && w.win0) mask = win_masks_q[5:0];
      else if (layer_en_q[6] && w.win1) mask = win_masks_q[11:6];
      else if (layer_en_q[7] && w.spr_win) mask = win_masks_q[23:18];
      else mask = win_masks_q[17:12];
    end
    prio0 = 4; prio1 = 4;
    lay0 = hppc_pkg::LayerBackdrop; lay1 = hppc_pkg::LayerBackdrop;
    alpha_obj = 1'b0;
    if (any_bg) begin
      for (int p = 3; p >= 0; p--) begin
        for (int b = hi; b >= lo; b--) begin
          if (layer_en_q[b] && bg_prio_q[2*b +: 2] == p && mask[b] && !w.bg[b][15]) begin
            lay1 = lay0; lay0 = 3'(b);
            prio1 = prio0; prio0 = p;
          end
        end
      end
    end
    if (mask[4] && layer_en_q[4] && !w.spr[15]) begin
      sp = w.spr_prio;
      if (sp <= prio0) begin
        lay1 = lay0; lay0 = hppc_pkg::LayerSprite; alpha_obj = w.spr_alpha;
      end else if (sp <= prio1) begin
        lay1 = hppc_pkg::LayerSprite;
      end
    end
    color = layer_rgb(lay0, w);
    if (mask[5] || alpha_obj) begin
      fx = blend_ctl_q[1:0];
      has_dst = blend_ctl_q[2 + lay0];
      has_src = blend_ctl_q[8 + lay1];
      below = layer_rgb(lay1, w);
      if (alpha_obj && has_src) color = mix_color(color, below, hppc_pkg::FxAlpha);
      else if (has_dst && fx != hppc_pkg::FxNone && (has_src || fx != hppc_pkg::FxAlpha))
        color = mix_color(color, below, fx);
    end
    return {color[4:0], 3'b0, color[9:5], 3'b0, color[14:10], 3'b0};
  endfunction

  always @(posedge clk_i) busy_q <= busy;

  // Pixel driver: one word per start, random gaps between words.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy_q) begin
        expected_rgb.push_back(compose_pixel(pending_words.pop_front()));
        gap_left = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap_left = 0;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (driving && pending_words.size() > 0) begin
        start           <= 1'b1;
        bg0_pixel       <= pending_words[0].bg[0];
        bg1_pixel       <= pending_words[0].bg[1];
        bg2_pixel       <= pending_words[0].bg[2];
        bg3_pixel       <= pending_words[0].bg[3];
        sprite_pixel    <= pending_words[0].spr;
        sprite_priority <= pending_words[0].spr_prio;
        sprite_alpha    <= pending_words[0].spr_alpha;
        sprite_window   <= pending_words[0].spr_win;
        inside_win0     <= pending_words[0].win0;
        inside_win1     <= pending_words[0].win1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor and idle watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (done) begin
        if (expected_rgb.size() == 0) begin
          $error("unexpected pixel_rgb: actual %06h", pixel_rgb);
          fail_count++;
        end else begin
          if (expected_rgb[0] !== pixel_rgb) begin
            $error("pixel_rgb mismatch: expected %06h actual %06h", expected_rgb[0], pixel_rgb);
            fail_count++;
          end
          void'(expected_rgb.pop_front());
        end
      end
      if (idle_cycles >= 5000) begin
        $display("handheld_ppu_pixel_compositor test failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      hppc_pkg::RegBgMode:    mode_q = val[2:0];
      hppc_pkg::RegBlank:     blank_q = val[0];
      hppc_pkg::RegLayerEn:   layer_en_q = val[7:0];
      hppc_pkg::RegBgPrio:    bg_prio_q = val[7:0];
      hppc_pkg::RegWinMasks:  win_masks_q = val;
      hppc_pkg::RegBlendCtl:  blend_ctl_q = val[13:0];
      hppc_pkg::RegBlendCoef: coef_q = val[14:0];
      default:                backdrop_q = val[14:0];
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_pixels();
    while (pending_words.size() > 0 || start || expected_rgb.size() > 0) @(posedge clk_i);
    driving = 1'b0;
    repeat (8) @(posedge clk_i);
  endtask

  function automatic pix_word_t rand_word(input bit opaque_bias);
    pix_word_t w;
    for (int i = 0; i < 4; i++) begin
      w.bg[i] = 16'($urandom);
      if (opaque_bias && $urandom_range(0, 2) != 0) w.bg[i][15] = 1'b0;
    end
    w.spr = 16'($urandom);
    if (opaque_bias && $urandom_range(0, 1) != 0) w.spr[15] = 1'b0;
    w.spr_prio  = 2'($urandom);
    w.spr_alpha = 1'($urandom);
    w.spr_win   = 1'($urandom);
    w.win0      = 1'($urandom);
    w.win1      = 1'($urandom);
    return w;
  endfunction

  task automatic config_phase(input bit extreme);
    logic [23:0] v [8];
    v[0] = 24'($urandom_range(0, 7));
    v[1] = 24'($urandom_range(0, 9) == 0);
    v[2] = 24'($urandom);
    v[3] = 24'($urandom);
    v[4] = 24'($urandom);
    v[5] = 24'($urandom);
    v[6] = 24'($urandom);
    v[7] = 24'($urandom);
    if (extreme) begin
      v[0] = $urandom_range(0, 1) ? 24'd0 : 24'd7;
      v[1] = 24'd0;
      v[2] = $urandom_range(0, 1) ? 24'hFF : 24'h1F;
      v[3] = $urandom_range(0, 1) ? 24'hFF : 24'h00;
      v[4] = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      v[5] = $urandom_range(0, 1) ? 24'h3FFF : 24'h3F01;
      v[6] = $urandom_range(0, 1) ? 24'h7FFF : 24'h0000;
      v[7] = $urandom_range(0, 1) ? 24'h7FFF : 24'h0000;
    end
    for (int i = 0; i < 8; i++) begin
      write_reg(3'(i), v[i]);
      repeat ($urandom_range(0, 2)) @(posedge clk_i);
    end
  endtask

  initial begin
    pix_word_t w;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words: reset registers, then extremes under each effect.
    for (int fx = 0; fx < 5; fx++) begin
      if (fx > 0) begin
        write_reg(hppc_pkg::RegBgMode, 24'd0);
        write_reg(hppc_pkg::RegBlank, (fx == 4) ? 24'd1 : 24'd0);
        write_reg(hppc_pkg::RegLayerEn, (fx == 3) ? 24'hFF : 24'h1F);
        write_reg(hppc_pkg::RegBgPrio, 24'h1B);
        write_reg(hppc_pkg::RegWinMasks, 24'h3F_0F_3F ^ 24'(fx));
        write_reg(hppc_pkg::RegBlendCtl, 24'({6'h3F, 6'h3F, 2'(fx)}));
        write_reg(hppc_pkg::RegBlendCoef, (fx == 2) ? 24'h7FFF : 24'h4210);
        write_reg(hppc_pkg::RegBackdrop, 24'h7FFF);
      end
      for (int i = 0; i < 5; i++) begin
        w = rand_word(1'b1);
        if (i == 0) begin
          for (int b = 0; b < 4; b++) w.bg[b] = 16'h7FFF;
          w.spr = 16'h7FFF; w.spr_alpha = 1'b1; w.spr_prio = 2'd0;
        end
        if (i == 1) begin
          for (int b = 0; b < 4; b++) w.bg[b] = 16'h8000;
          w.spr = 16'hFFFF; w.spr_prio = 2'd3;
        end
        pending_words.push_back(w);
      end
      driving = 1'b1;
      drain_pixels();
    end

    // Random phases under random and extreme register settings.
    for (int ph = 0; ph < 26; ph++) begin
      config_phase(ph % 4 == 1);
      for (int i = 0; i < 50; i++) pending_words.push_back(rand_word($urandom_range(0, 4) != 0));
      driving = 1'b1;
      drain_pixels();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("handheld_ppu_pixel_compositor test passed");
    end else begin
      $display("handheld_ppu_pixel_compositor test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/hppc_pkg.sv
design/hppc_effect.sv
design/handheld_ppu_pixel_compositor.sv
dv/testbench.sv
